/* sv/smv_pkg.sv */
// ----------------------------------------------------------------------------
// Servo move sequencer package
// Shared types and codes for the lid and arm servo sequencer.
// ----------------------------------------------------------------------------
package smv_pkg;

  // Angles are whole degrees in the range 0..180.
  localparam int unsigned ANGLE_BITS = 8;
  localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = 8'd180;

  // Configuration register file.
  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LID_OPEN      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LID_CLOSED    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARM_EXTENDED  = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARM_RETRACTED = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ARM_NEAR_EXT  = 3'd4;

  // Item kinds.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_POLL  = 1'b1;

  // Servo selection.
  localparam logic SERVO_LID = 1'b0;
  localparam logic SERVO_ARM = 1'b1;

  // Result status codes.
  localparam logic [1:0] STATUS_EXEC        = 2'd0;
  localparam logic [1:0] STATUS_DONE        = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  // Action codes; anything from ACT_NONE upwards is a generic action.
  typedef enum logic [3:0] {
    ACT_OPEN_LID        = 4'd0,
    ACT_CLOSE_LID       = 4'd1,
    ACT_EXTEND_ARM      = 4'd2,
    ACT_RETRACT_ARM     = 4'd3,
    ACT_MOVE_LID        = 4'd4,
    ACT_PEEK_LID        = 4'd5,
    ACT_UNPEEK_LID      = 4'd6,
    ACT_RAMP_OPEN_LID   = 4'd7,
    ACT_RAMP_CLOSE_LID  = 4'd8,
    ACT_MOVE_ARM        = 4'd9,
    ACT_RAMP_EXTEND_ARM = 4'd10,
    ACT_RAMP_NEAR_ARM   = 4'd11,
    ACT_RAMP_RETRACT    = 4'd12,
    ACT_NONE            = 4'd13
  } action_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] lid_open_angle;
    logic [ANGLE_BITS-1:0] lid_closed_angle;
    logic [ANGLE_BITS-1:0] arm_extended_angle;
    logic [ANGLE_BITS-1:0] arm_retracted_angle;
    logic [ANGLE_BITS-1:0] arm_near_extended_angle;
  } cfg_t;

  typedef struct packed {
    logic                  func;
    logic [3:0]            action_code;
    logic [ANGLE_BITS-1:0] first_value;
    logic [ANGLE_BITS-1:0] second_value;
    logic [15:0]           step_delay;
    logic                  ms_tick;
  } item_t;

  typedef struct packed {
    logic                  write_valid;
    logic                  servo_select;
    logic [ANGLE_BITS-1:0] servo_angle;
    logic [1:0]            status;
    logic                  switch_off_flag;
  } result_t;

endpackage

/* sv/smv_cfg.sv */
// ----------------------------------------------------------------------------
// Servo sequencer configuration registers
// Holds the five preset angles written over the configuration channel.
// ----------------------------------------------------------------------------
module smv_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smv_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [smv_pkg::ANGLE_BITS-1:0]       cfg_data,
  output smv_pkg::cfg_t                        cfg
);
  import smv_pkg::*;

  logic wr;

  // Writes are always taken; an index beyond the register list is dropped.
  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      case (cfg_index)
        REG_LID_OPEN:      cfg.lid_open_angle          <= cfg_data;
        REG_LID_CLOSED:    cfg.lid_closed_angle        <= cfg_data;
        REG_ARM_EXTENDED:  cfg.arm_extended_angle      <= cfg_data;
        REG_ARM_RETRACTED: cfg.arm_retracted_angle     <= cfg_data;
        REG_ARM_NEAR_EXT:  cfg.arm_near_extended_angle <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/smv_core.sv */
// ----------------------------------------------------------------------------
// Servo sequencer core
// Action state and the single-pass start and poll logic for one item.
// ----------------------------------------------------------------------------
module smv_core #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  smv_pkg::item_t   item,
  input  smv_pkg::cfg_t    cfg,
  output smv_pkg::result_t result
);
  import smv_pkg::*;

  // Action state.
  logic [ANGLE_BITS-1:0] current_angle, current_angle_next;
  logic [ANGLE_BITS-1:0] target_angle, target_angle_next;
  logic [DELAY_BITS-1:0] delay_setting, delay_setting_next;
  logic [DELAY_BITS-1:0] elapsed_count, elapsed_count_next;
  logic                  servo_in_use, servo_in_use_next;
  action_t               active_action, active_action_next;
  logic                  switch_off_seen, switch_off_seen_next;

  // Helpers.
  logic [31:0]           delay_a_wide;
  logic [31:0]           delay_b_wide;
  logic [31:0]           delay_c_wide;
  logic [ANGLE_BITS:0]   peek_sum;
  logic [ANGLE_BITS-1:0] peek_diff;
  logic [ANGLE_BITS-1:0] peek_angle;
  logic [DELAY_BITS:0]   tick_sum;
  logic                  step_fire;

  // Delay sources widened then cut to the configured delay width.
  assign delay_a_wide = 32'(item.step_delay);
  assign delay_b_wide = 32'(item.second_value);
  assign delay_c_wide = 32'(item.first_value);

  // Peek angle: closed angle moved toward open by the peek degrees, held to 0..180.
  always_comb begin
    peek_sum  = {1'b0, cfg.lid_closed_angle} + {1'b0, item.first_value};
    peek_diff = cfg.lid_closed_angle - item.first_value;
    if (cfg.lid_closed_angle > cfg.lid_open_angle) begin
      if (item.first_value > cfg.lid_closed_angle) begin
        peek_angle = '0;
      end else if (peek_diff > ANGLE_MAX) begin
        peek_angle = ANGLE_MAX;
      end else begin
        peek_angle = peek_diff;
      end
    end else if (peek_sum > {1'b0, ANGLE_MAX}) begin
      peek_angle = ANGLE_MAX;
    end else begin
      peek_angle = peek_sum[ANGLE_BITS-1:0];
    end
  end

  // Millisecond count and step event for ramps.
  assign tick_sum  = {1'b0, elapsed_count} + (DELAY_BITS+1)'(item.ms_tick);
  assign step_fire = (delay_setting == '0) || (tick_sum > {1'b0, delay_setting});

  // Start and poll handling.
  always_comb begin
    current_angle_next   = current_angle;
    target_angle_next    = target_angle;
    delay_setting_next   = delay_setting;
    elapsed_count_next   = elapsed_count;
    servo_in_use_next    = servo_in_use;
    active_action_next   = active_action;
    switch_off_seen_next = switch_off_seen;
    result               = '0;

    if (item.func == FUNC_START) begin
      elapsed_count_next   = '0;
      switch_off_seen_next = 1'b0;
      active_action_next   = (item.action_code >= ACT_NONE) ? ACT_NONE
                                                            : action_t'(item.action_code);
      case (item.action_code)
        ACT_OPEN_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = cfg.lid_open_angle;
        end
        ACT_CLOSE_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = cfg.lid_closed_angle;
        end
        ACT_EXTEND_ARM: begin
          servo_in_use_next  = SERVO_ARM;
          current_angle_next = cfg.arm_extended_angle;
        end
        ACT_RETRACT_ARM: begin
          servo_in_use_next  = SERVO_ARM;
          current_angle_next = cfg.arm_retracted_angle;
        end
        ACT_MOVE_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = item.first_value;
          target_angle_next  = item.second_value;
          delay_setting_next = delay_a_wide[DELAY_BITS-1:0];
        end
        ACT_PEEK_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = cfg.lid_closed_angle;
          target_angle_next  = peek_angle;
          delay_setting_next = delay_b_wide[DELAY_BITS-1:0];
        end
        ACT_UNPEEK_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = peek_angle;
          target_angle_next  = cfg.lid_closed_angle;
          delay_setting_next = delay_b_wide[DELAY_BITS-1:0];
        end
        ACT_RAMP_OPEN_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = cfg.lid_closed_angle;
          target_angle_next  = cfg.lid_open_angle;
          delay_setting_next = delay_c_wide[DELAY_BITS-1:0];
        end
        ACT_RAMP_CLOSE_LID: begin
          servo_in_use_next  = SERVO_LID;
          current_angle_next = cfg.lid_open_angle;
          target_angle_next  = cfg.lid_closed_angle;
          delay_setting_next = delay_c_wide[DELAY_BITS-1:0];
        end
        ACT_MOVE_ARM: begin
          servo_in_use_next  = SERVO_ARM;
          current_angle_next = item.first_value;
          target_angle_next  = item.second_value;
          delay_setting_next = delay_a_wide[DELAY_BITS-1:0];
        end
        ACT_RAMP_EXTEND_ARM: begin
          servo_in_use_next  = SERVO_ARM;
          current_angle_next = cfg.arm_retracted_angle;
          target_angle_next  = cfg.arm_extended_angle;
          delay_setting_next = delay_c_wide[DELAY_BITS-1:0];
        end
        ACT_RAMP_NEAR_ARM: begin
          servo_in_use_next  = SERVO_ARM;
          current_angle_next = cfg.arm_retracted_angle;
          target_angle_next  = cfg.arm_near_extended_angle;
          delay_setting_next = delay_c_wide[DELAY_BITS-1:0];
        end
        ACT_RAMP_RETRACT: begin
          servo_in_use_next  = SERVO_ARM;
          current_angle_next = cfg.arm_extended_angle;
          target_angle_next  = cfg.arm_retracted_angle;
          delay_setting_next = delay_c_wide[DELAY_BITS-1:0];
        end
        default: ;
      endcase
      result.status = (item.action_code >= ACT_NONE) ? STATUS_UNSUPPORTED : STATUS_EXEC;
    end else if (active_action >= ACT_NONE) begin
      result.status = STATUS_UNSUPPORTED;
    end else if (active_action <= ACT_RETRACT_ARM) begin
      // Immediate action: write the preset angle and complete.
      if (active_action == ACT_EXTEND_ARM) begin
        switch_off_seen_next = 1'b1;
      end
      result.write_valid  = 1'b1;
      result.servo_select = servo_in_use;
      result.servo_angle  = current_angle;
      result.status       = STATUS_DONE;
    end else begin
      // Ramp: count milliseconds and step one degree on each step event.
      elapsed_count_next = tick_sum[DELAY_BITS] ? '1 : tick_sum[DELAY_BITS-1:0];
      if (step_fire) begin
        elapsed_count_next = '0;
        if (current_angle < target_angle) begin
          current_angle_next  = current_angle + 1'b1;
          result.write_valid  = 1'b1;
          result.servo_select = servo_in_use;
          result.servo_angle  = current_angle + 1'b1;
        end else if (current_angle > target_angle) begin
          current_angle_next  = current_angle - 1'b1;
          result.write_valid  = 1'b1;
          result.servo_select = servo_in_use;
          result.servo_angle  = current_angle - 1'b1;
        end else begin
          result.status = STATUS_DONE;
          if (active_action == ACT_RAMP_EXTEND_ARM) begin
            switch_off_seen_next = 1'b1;
          end
        end
      end
    end

    result.switch_off_flag = switch_off_seen_next;
  end

  // State update, one item per enabled cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_angle   <= '0;
      target_angle    <= '0;
      delay_setting   <= '0;
      elapsed_count   <= '0;
      servo_in_use    <= SERVO_LID;
      active_action   <= ACT_NONE;
      switch_off_seen <= 1'b0;
    end else if (en) begin
      current_angle   <= current_angle_next;
      target_angle    <= target_angle_next;
      delay_setting   <= delay_setting_next;
      elapsed_count   <= elapsed_count_next;
      servo_in_use    <= servo_in_use_next;
      active_action   <= active_action_next;
      switch_off_seen <= switch_off_seen_next;
    end
  end

endmodule

/* sv/servo_move_sequencer.sv */
// ----------------------------------------------------------------------------
// Servo move sequencer
// Lid and arm servo action sequencer with one-degree slew-rate limited ramps.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle and returns one result for
// each via the input register and then the result register. Each item is
// handled in a single pass from the input register through the action state
// update into the result register, so the rate is bounded only by result-side
// back-pressure. Preset angles must be written over the configuration channel
// only while the block is idle; the block itself does not enforce this.
module servo_move_sequencer #(
  parameter int unsigned DELAY_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Item input.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // action_code[3:0], first_value[11:4], second_value[19:12],
  // step_delay[35:20], ms_tick[36], zero padding above.
  input  logic [39:0]                        s_tdata,
  // func[0].
  input  logic                               s_tuser,
  // Result output.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // servo_select[0], servo_angle[8:1], status[10:9], switch_off_flag[11],
  // zero padding above.
  output logic [15:0]                        m_tdata,
  // write_valid[0].
  output logic                               m_tuser,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smv_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [smv_pkg::ANGLE_BITS-1:0]     cfg_data
);
  import smv_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  smv_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves on whenever the result register is free or draining.
  assign advance  = in_valid & (~m_tvalid | m_tready);
  assign s_tready = ~in_valid | advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid & s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid & s_tready) begin
      in_item.func         <= s_tuser;
      in_item.action_code  <= s_tdata[3:0];
      in_item.first_value  <= s_tdata[11:4];
      in_item.second_value <= s_tdata[19:12];
      in_item.step_delay   <= s_tdata[35:20];
      in_item.ms_tick      <= s_tdata[36];
    end
  end

  smv_core #(
    .DELAY_BITS (DELAY_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  // Pack the result transaction.
  assign m_tuser = out_result.write_valid;
  assign m_tdata = {4'b0000, out_result.switch_off_flag, out_result.status,
                    out_result.servo_angle, out_result.servo_select};

endmodule

/* tb/tb_servo_move_sequencer.sv */
// ----------------------------------------------------------------------------
// Servo move sequencer testbench
// Streams start and poll items into the sequencer under random idling on both
// sides, predicts every result from a behavioural copy of the action state,
// and compares each returned result field by field in order.
// ----------------------------------------------------------------------------
module tb_servo_move_sequencer;
  import smv_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [ANGLE_BITS-1:0] cfg_data = '0;

  servo_move_sequencer uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the preset angles and of the sequencer's action state.
  cfg_t preset;
  logic [ANGLE_BITS-1:0] cur_angle;
  logic [ANGLE_BITS-1:0] end_angle;
  logic [15:0] step_wait;
  logic [15:0] ms_elapsed;
  logic servo_sel;
  action_t running_action;
  logic switch_off_seen;

  item_t pending_items[$];
  result_t expected_results[$];
  item_t offered_item = '0;
  bit item_taken = 1'b0;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit full_rate = 1'b0;
  bit hold_off_req = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;

  // Idle length between transactions: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (full_rate) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  // Per-degree delay: mostly short so that ramps finish, sometimes large.
  function automatic logic [15:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 16'd0;
    if (r < 85) return 16'($urandom_range(3, 1));
    if (r < 97) return 16'($urandom_range(20, 4));
    return 16'($urandom_range(180, 0));
  endfunction

  function automatic void load_ramp(logic servo, logic [7:0] from_angle,
                                    logic [7:0] to_angle, logic [15:0] dly);
    servo_sel = servo;
    cur_angle = from_angle;
    end_angle = to_angle;
    step_wait = dly;
  endfunction

  // Closed angle moved toward the open angle, held within 0..180 degrees.
  function automatic logic [7:0] peek_target(logic [7:0] peek);
    int v;
    v = int'(preset.lid_closed_angle);
    if (preset.lid_closed_angle > preset.lid_open_angle) v -= int'(peek);
    else v += int'(peek);
    if (v < 0) v = 0;
    if (v > int'(ANGLE_MAX)) v = int'(ANGLE_MAX);
    return 8'(v);
  endfunction

  // Advances the action state by one item and returns the servo write it causes.
  function automatic result_t next_servo_write(item_t it);
    result_t r;
    logic [16:0] sum;
    logic fire;
    r = '0;
    if (it.func == FUNC_START) begin
      ms_elapsed = '0;
      switch_off_seen = 1'b0;
      running_action = (it.action_code >= ACT_NONE) ? ACT_NONE : action_t'(it.action_code);
      case (running_action)
        ACT_OPEN_LID: begin
          servo_sel = SERVO_LID;
          cur_angle = preset.lid_open_angle;
        end
        ACT_CLOSE_LID: begin
          servo_sel = SERVO_LID;
          cur_angle = preset.lid_closed_angle;
        end
        ACT_EXTEND_ARM: begin
          servo_sel = SERVO_ARM;
          cur_angle = preset.arm_extended_angle;
        end
        ACT_RETRACT_ARM: begin
          servo_sel = SERVO_ARM;
          cur_angle = preset.arm_retracted_angle;
        end
        ACT_MOVE_LID:
          load_ramp(SERVO_LID, it.first_value, it.second_value, it.step_delay);
        ACT_PEEK_LID:
          load_ramp(SERVO_LID, preset.lid_closed_angle, peek_target(it.first_value),
                    {8'h00, it.second_value});
        ACT_UNPEEK_LID:
          load_ramp(SERVO_LID, peek_target(it.first_value), preset.lid_closed_angle,
                    {8'h00, it.second_value});
        ACT_RAMP_OPEN_LID:
          load_ramp(SERVO_LID, preset.lid_closed_angle, preset.lid_open_angle,
                    {8'h00, it.first_value});
        ACT_RAMP_CLOSE_LID:
          load_ramp(SERVO_LID, preset.lid_open_angle, preset.lid_closed_angle,
                    {8'h00, it.first_value});
        ACT_MOVE_ARM:
          load_ramp(SERVO_ARM, it.first_value, it.second_value, it.step_delay);
        ACT_RAMP_EXTEND_ARM:
          load_ramp(SERVO_ARM, preset.arm_retracted_angle, preset.arm_extended_angle,
                    {8'h00, it.first_value});
        ACT_RAMP_NEAR_ARM:
          load_ramp(SERVO_ARM, preset.arm_retracted_angle,
                    preset.arm_near_extended_angle, {8'h00, it.first_value});
        ACT_RAMP_RETRACT:
          load_ramp(SERVO_ARM, preset.arm_extended_angle, preset.arm_retracted_angle,
                    {8'h00, it.first_value});
        default: ;
      endcase
      r.status = (running_action == ACT_NONE) ? STATUS_UNSUPPORTED : STATUS_EXEC;
    end else if (running_action == ACT_NONE) begin
      r.status = STATUS_UNSUPPORTED;
    end else if (running_action <= ACT_RETRACT_ARM) begin
      // Preset actions write their latched angle and complete on every poll.
      if (running_action == ACT_EXTEND_ARM) switch_off_seen = 1'b1;
      r.write_valid = 1'b1;
      r.servo_select = servo_sel;
      r.servo_angle = cur_angle;
      r.status = STATUS_DONE;
    end else begin
      // Ramp: the compare uses the full sum, the counter saturates.
      sum = {1'b0, ms_elapsed} + 17'(it.ms_tick);
      fire = (step_wait == '0) || (sum > {1'b0, step_wait});
      ms_elapsed = sum[16] ? 16'hFFFF : sum[15:0];
      if (fire) begin
        ms_elapsed = '0;
        if (cur_angle != end_angle) begin
          cur_angle = (cur_angle < end_angle) ? cur_angle + 8'd1 : cur_angle - 8'd1;
          r.write_valid = 1'b1;
          r.servo_select = servo_sel;
          r.servo_angle = cur_angle;
        end else begin
          r.status = STATUS_DONE;
          if (running_action == ACT_RAMP_EXTEND_ARM) switch_off_seen = 1'b1;
        end
      end
    end
    r.switch_off_flag = switch_off_seen;
    return r;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: checks result transactions, then predicts for accepted items.
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual tdata %h tuser %b",
                   $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("write_valid", want.write_valid, m_tuser);
          check_field("servo_select", want.servo_select, m_tdata[0]);
          check_field("servo_angle", want.servo_angle, m_tdata[8:1]);
          check_field("status", want.status, m_tdata[10:9]);
          check_field("switch_off_flag", want.switch_off_flag, m_tdata[11]);
        end
      end
      if (s_tvalid && s_tready) begin
        expected_results.push_back(next_servo_write(offered_item));
        item_taken = 1'b1;
        items_taken++;
      end
    end
  end

  // Driver: offers queued items with random gaps, holding each until taken.
  always @(negedge clk) begin
    logic offer;
    offer = s_tvalid;
    if (!s_tvalid || item_taken) begin
      item_taken = 1'b0;
      offer = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_items.size() > 0) begin
        offered_item = pending_items.pop_front();
        offer = 1'b1;
        send_gap = pick_gap();
      end
    end
    s_tvalid <= offer;
    s_tdata <= {3'b000, offered_item.ms_tick, offered_item.step_delay,
                offered_item.second_value, offered_item.first_value,
                offered_item.action_code};
    s_tuser <= offered_item.func;
  end

  // Result side: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    logic rdy;
    if (hold_off_req) begin
      hold_left = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    rdy = 1'b0;
    if (hold_left > 0) begin
      hold_left--;
    end else if (recv_gap > 0) begin
      recv_gap--;
    end else begin
      rdy = 1'b1;
      recv_gap = pick_gap();
    end
    m_tready <= rdy;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_item(logic func, logic [3:0] code, logic [7:0] v1, logic [7:0] v2,
                            logic [15:0] dly, logic tick);
    item_t it;
    it.func = func;
    it.action_code = code;
    it.first_value = v1;
    it.second_value = v2;
    it.step_delay = dly;
    it.ms_tick = tick;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_poll(logic tick);
    queue_item(FUNC_POLL, 4'($urandom_range(15)), 8'($urandom_range(180)),
               8'($urandom_range(180)), 16'($urandom), tick);
  endtask

  // One start transaction with fitting content followed by a run of polls;
  // now and then some unstructured items instead.
  task automatic queue_action_run();
    logic [3:0] code;
    logic [7:0] v1;
    logic [7:0] v2;
    logic [15:0] dly;
    int unsigned polls;
    int unsigned n;
    int span;
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(3, 1);
      repeat (n)
        queue_item(1'($urandom), 4'($urandom_range(15)), 8'($urandom_range(180)),
                   8'($urandom_range(180)), 16'($urandom), 1'($urandom));
      return;
    end
    code = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 13)) : 4'($urandom_range(12));
    v1 = 8'($urandom_range(180));
    v2 = 8'($urandom_range(180));
    dly = 16'($urandom);
    if (code == ACT_MOVE_LID || code == ACT_MOVE_ARM) begin
      span = $urandom_range(3) == 0 ? 180 : 12;
      v2 = 8'($urandom_range((v1 + span > 180) ? 180 : v1 + span, (v1 < span) ? 0 : v1 - span));
      dly = pick_delay();
    end else if (code == ACT_PEEK_LID || code == ACT_UNPEEK_LID) begin
      if ($urandom_range(1) == 0) v1 = 8'($urandom_range(10));
      v2 = 8'(pick_delay());
    end else if (code > ACT_RETRACT_ARM && code < ACT_NONE) begin
      v1 = 8'(pick_delay());
    end
    queue_item(FUNC_START, code, v1, v2, dly, 1'($urandom));
    polls = $urandom_range(40, 1);
    repeat (polls) queue_poll($urandom_range(9) < 7);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [ANGLE_BITS-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_LID_OPEN: preset.lid_open_angle = val;
      REG_LID_CLOSED: preset.lid_closed_angle = val;
      REG_ARM_EXTENDED: preset.arm_extended_angle = val;
      REG_ARM_RETRACTED: preset.arm_retracted_angle = val;
      REG_ARM_NEAR_EXT: preset.arm_near_extended_angle = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_presets(logic [7:0] open_a, logic [7:0] closed_a, logic [7:0] ext_a,
                               logic [7:0] retr_a, logic [7:0] near_a);
    write_reg(REG_LID_OPEN, open_a);
    write_reg(REG_LID_CLOSED, closed_a);
    write_reg(REG_ARM_EXTENDED, ext_a);
    write_reg(REG_ARM_RETRACTED, retr_a);
    write_reg(REG_ARM_NEAR_EXT, near_a);
  endtask

  // Waits until every queued item has been taken and every result has come back.
  task automatic wait_idle();
    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk);
  endtask

  // Reset, directed items, random phases over several presets, long delay run.
  initial begin
    int unsigned goal;
    int unsigned base;
    preset = '0;
    cur_angle = '0;
    end_angle = '0;
    step_wait = '0;
    ms_elapsed = '0;
    servo_sel = SERVO_LID;
    running_action = ACT_NONE;
    switch_off_seen = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: no action, generic action, presets, ramps, peek saturation high.
    write_presets(8'd180, 8'd170, 8'd180, 8'd0, 8'd179);
    queue_poll(1'b1);
    queue_item(FUNC_START, 4'd14, 8'd0, 8'd0, 16'd0, 1'b0);
    queue_poll(1'b0);
    queue_item(FUNC_START, ACT_EXTEND_ARM, 8'd180, 8'd180, 16'hFFFF, 1'b1);
    queue_poll(1'b0);
    queue_item(FUNC_START, ACT_OPEN_LID, 8'd0, 8'd0, 16'd0, 1'b0);
    queue_poll(1'b1);
    queue_item(FUNC_START, ACT_MOVE_LID, 8'd0, 8'd1, 16'd0, 1'b0);
    repeat (3) queue_poll(1'b0);
    queue_item(FUNC_START, ACT_MOVE_ARM, 8'd180, 8'd179, 16'd1, 1'b1);
    queue_poll(1'b1);
    queue_poll(1'b0);
    repeat (3) queue_poll(1'b1);
    queue_item(FUNC_START, ACT_PEEK_LID, 8'd180, 8'd0, 16'd0, 1'b0);
    queue_poll(1'b0);
    wait_idle();

    // Directed: peek saturation low, arm extension completing with switch-off.
    write_presets(8'd10, 8'd20, 8'd100, 8'd101, 8'd0);
    queue_item(FUNC_START, ACT_PEEK_LID, 8'd180, 8'd0, 16'd0, 1'b1);
    queue_poll(1'b0);
    queue_item(FUNC_START, ACT_RAMP_EXTEND_ARM, 8'd0, 8'd0, 16'd0, 1'b0);
    repeat (3) queue_poll(1'b1);
    wait_idle();

    // Random phases, each with its own presets.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 0) begin
        write_presets(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      end else if (ph == 1) begin
        write_presets(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, ANGLE_MAX);
      end else if (ph % 3 == 2) begin
        write_presets(8'($urandom_range(180)), 8'($urandom_range(180)),
                      8'($urandom_range(180)), 8'($urandom_range(180)),
                      8'($urandom_range(180)));
      end else begin
        base = $urandom_range(172, 8);
        write_presets(8'($urandom_range(base + 8, base - 8)),
                      8'($urandom_range(base + 8, base - 8)),
                      8'($urandom_range(base + 8, base - 8)),
                      8'($urandom_range(base + 8, base - 8)),
                      8'($urandom_range(base + 8, base - 8)));
      end
      full_rate = (ph == 4);
      goal = items_queued + 45;
      while (items_queued < goal) queue_action_run();
      // Long result-side hold-off while items keep coming.
      if (ph == 1) hold_off_req = 1'b1;
      wait_idle();
    end

    // Largest delay: ticking polls well short of it never step the ramp.
    full_rate = 1'b1;
    queue_item(FUNC_START, ACT_MOVE_LID, 8'd0, 8'd1, 16'hFFFF, 1'b0);
    repeat (8) queue_poll(1'b1);
    repeat (2) queue_poll(1'b0);
    wait_idle();

    repeat (20) @(posedge clk);
    if (error_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

/* files.f */
sv/smv_pkg.sv
sv/smv_cfg.sv
sv/smv_core.sv
sv/servo_move_sequencer.sv
tb/tb_servo_move_sequencer.sv
